### src/sld_pkg.sv
package sld_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = 1'b1;

  localparam logic [7:0]  FIRST_SYNC_RST  = 8'hAA;
  localparam logic [7:0]  SECOND_SYNC_RST = 8'h55;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REFL   = 16'hA001;
  localparam logic [7:0]  MIN_LENGTH      = 8'd2;

  localparam int unsigned OUT_DATA_W = 64;

  typedef enum logic [1:0] {
    HUNT_FIRST = 2'd0,
    SEEN_FIRST = 2'd1,
    COLLECT    = 2'd2
  } hunt_state_t;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_BAD_LEN = 2'd2
  } frame_status_t;

  // one classified byte handed from the front to the back
  typedef struct packed {
    logic       init;       // restart the crc before this byte
    logic       feed;       // byte is covered by the crc
    logic       hold_lo;    // byte is the carried crc, low half
    logic       hold_hi;    // byte is the carried crc, high half
    logic       emit_body;  // pass the byte out as a body byte
    logic       verdict;    // close the frame
    logic       bad_len;    // verdict is a bad length
    logic [7:0] data;
    logic [7:0] index;
    logic [7:0] length;
  } q_entry_t;

  // result payload, packed as it leaves on tdata (lowest field last)
  typedef struct packed {
    logic [5:0]    pad;
    logic [15:0]   computed_crc;
    logic [15:0]   received_crc;
    frame_status_t frame_status;
    logic [7:0]    frame_length;
    logic [7:0]    body_index;
    logic [7:0]    body_byte;
  } out_data_t;

  typedef struct packed {
    logic      result_kind;
    logic      last_of_frame;
    out_data_t data;
  } result_t;

  // crc-16/modbus, one byte through the reflected polynomial
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### src/sld_front.sv
module sld_front
  import sld_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_accept,
  input  logic [7:0]           in_byte,
  output logic                 push,
  output q_entry_t             entry
);

  hunt_state_t hunt_r, hunt_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  first_sync_r, second_sync_r;

  logic [8:0]  pos_plus2;
  logic [8:0]  pos_plus1;

  assign pos_plus2 = {1'b0, count_r} + 9'd2;
  assign pos_plus1 = {1'b0, count_r} + 9'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_sync_r  <= FIRST_SYNC_RST;
      second_sync_r <= SECOND_SYNC_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FIRST_SYNC:  first_sync_r  <= cfg_data;
        CFG_SECOND_SYNC: second_sync_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunt_r  <= HUNT_FIRST;
      len_r   <= '0;
      count_r <= '0;
    end else begin
      hunt_r  <= hunt_nxt;
      len_r   <= len_nxt;
      count_r <= count_nxt;
    end
  end

  // next state
  always_comb begin
    hunt_nxt  = hunt_r;
    len_nxt   = len_r;
    count_nxt = count_r;
    if (in_accept) begin
      case (hunt_r)
        HUNT_FIRST: begin
          if (in_byte == first_sync_r) begin
            if (in_byte == second_sync_r) begin
              hunt_nxt  = COLLECT;
              count_nxt = '0;
            end else begin
              hunt_nxt = SEEN_FIRST;
            end
          end
        end
        SEEN_FIRST: begin
          if (in_byte == second_sync_r) begin
            hunt_nxt  = COLLECT;
            count_nxt = '0;
          end
        end
        COLLECT: begin
          if (count_r == '0) begin
            len_nxt = in_byte;
            if (in_byte < MIN_LENGTH) begin
              hunt_nxt = HUNT_FIRST;
            end else begin
              count_nxt = 8'd1;
            end
          end else if (count_r >= len_r) begin
            hunt_nxt  = HUNT_FIRST;
            count_nxt = '0;
          end else begin
            count_nxt = pos_plus1[7:0];
          end
        end
        default: hunt_nxt = HUNT_FIRST;
      endcase
    end
  end

  // classification of the byte into a queue entry
  always_comb begin
    push       = 1'b0;
    entry      = '0;
    entry.data = in_byte;
    if (in_accept && hunt_r == COLLECT) begin
      push = 1'b1;
      if (count_r == '0) begin
        entry.length = in_byte;
        if (in_byte < MIN_LENGTH) begin
          entry.verdict = 1'b1;
          entry.bad_len = 1'b1;
        end else begin
          entry.init    = 1'b1;
          entry.feed    = (in_byte > MIN_LENGTH);
          entry.hold_lo = (in_byte == MIN_LENGTH);
        end
      end else if (count_r >= len_r) begin
        entry.length  = len_r;
        entry.verdict = 1'b1;
      end else begin
        entry.length    = len_r;
        entry.feed      = (pos_plus2 < {1'b0, len_r});
        entry.emit_body = (pos_plus2 < {1'b0, len_r});
        entry.hold_lo   = (pos_plus2 == {1'b0, len_r});
        entry.hold_hi   = (pos_plus1 == {1'b0, len_r});
        entry.index     = count_r - 8'd1;
      end
    end
  end

endmodule

### src/sld_queue.sv
module sld_queue
  import sld_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     ready,
  input  logic     pop,
  output logic     head_valid,
  output q_entry_t head_entry
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  q_entry_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign ready      = (count_r != FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_entry = mem[rd_ptr_r];
  assign do_push    = push && ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### src/sld_back.sv
module sld_back
  import sld_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     head_valid,
  input  q_entry_t head_entry,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  out_result
);

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     result_r, result_nxt;
  logic [15:0] crc_base;
  logic [15:0] rx_crc;

  assign pop      = head_valid && (!out_valid_r || out_ready);
  assign crc_base = head_entry.init ? CRC_INIT : crc_r;
  assign rx_crc   = {hi_r, lo_r};

  always_comb begin
    crc_nxt       = crc_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r && !out_ready;
    result_nxt    = result_r;
    if (pop) begin
      if (head_entry.feed) begin
        crc_nxt = crc_feed(crc_base, head_entry.data);
      end else begin
        crc_nxt = crc_base;
      end
      if (head_entry.hold_lo) begin
        lo_nxt = head_entry.data;
      end
      if (head_entry.hold_hi) begin
        hi_nxt = head_entry.data;
      end
      out_valid_nxt                = head_entry.emit_body || head_entry.verdict;
      result_nxt                   = '0;
      result_nxt.data.frame_length = head_entry.length;
      if (head_entry.verdict) begin
        result_nxt.result_kind   = 1'b1;
        result_nxt.last_of_frame = 1'b1;
        if (head_entry.bad_len) begin
          result_nxt.data.frame_status = ST_BAD_LEN;
        end else begin
          result_nxt.data.received_crc = rx_crc;
          result_nxt.data.computed_crc = crc_r;
          result_nxt.data.frame_status = (rx_crc == crc_r) ? ST_GOOD : ST_CRC_ERR;
        end
      end else begin
        result_nxt.data.body_byte  = head_entry.data;
        result_nxt.data.body_index = head_entry.index;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r    <= crc_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    result_r <= result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

endmodule

### src/sync_length_crc16_deframer_top.sv
// Sync / length / crc-16 deframer. Received bytes enter one per transaction on the
// in_ side; the block hunts for the first and then the second sync byte (an unmatched
// byte after the first sync just keeps it waiting), takes a length byte L and then
// L-1 more bytes. Body bytes (type plus payload) leave at once with their index; the
// last two packet bytes are the carried crc-16/modbus value, low byte first, checked
// against a crc (init 0xffff) over the length byte and the body. The byte after the
// packet is swallowed and closes the frame with a verdict transaction: good, crc
// mismatch, or bad length (L below two, reported on the length byte itself). Hunting
// bytes, crc bytes and sync bytes produce no result. Rate: one byte per clock,
// sustained while out_ takes results; a body or verdict byte is stored in the queue,
// and its result is then loaded into the output register that drives out_. The limit
// is the one-byte crc step in the back end. A front end classifies each byte, a short
// queue (QUEUE_DEPTH entries) decouples it from the back end that runs the crc and
// holds the result register, so input is still taken while a result waits to be read,
// until the queue is full. The user is to write the sync values through the cfg_ port
// only while the block is idle; the block itself does not enforce this.
module sync_length_crc16_deframer_top
  import sld_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration: index 0 first sync, index 1 second sync
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]            cfg_data,
  // received bytes
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // rx_byte
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // body_byte[7:0], body_index[15:8], frame_length[23:16], frame_status[25:24],
  // received_crc[41:26], computed_crc[57:42], zero fill[63:58]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,  // result_kind
  output logic                  out_tlast   // last_of_frame
);

  logic     in_accept;
  logic     push;
  q_entry_t push_entry;
  logic     pop;
  logic     head_valid;
  q_entry_t head_entry;
  result_t  result;

  // a transaction on the input side
  assign in_accept = in_tvalid && in_tready;

  // front: sync hunt, length and position tracking, byte classification
  sld_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .in_byte   (in_tdata),
    .push      (push),
    .entry     (push_entry)
  );

  // decoupling queue; its free space is the input ready
  sld_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .ready      (in_tready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // back: crc accumulation, carried crc capture, verdict and output register
  sld_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (result)
  );

  assign out_tdata = result.data;
  assign out_tuser = result.result_kind;
  assign out_tlast = result.last_of_frame;

endmodule

### src/sld_checker.sv
module sld_checker
  import sld_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser,
  input logic                  out_tlast
);

  out_data_t d;
  assign d = out_data_t'(out_tdata);

  // no result straight after reset
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present right after reset");

  // input back-pressure only builds up behind a stalled result
  a_ready_drop_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without a stalled result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // a body byte lies before the two crc bytes of its frame
  a_body_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      ({1'b0, d.body_index} + 9'd3 <= {1'b0, d.frame_length}) && !out_tlast)
    else $error("body index outside the frame body");

  // a good verdict means the carried and computed crc agree
  a_good_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && d.frame_status == ST_GOOD |->
      d.received_crc == d.computed_crc && out_tlast)
    else $error("good verdict with differing crc");

endmodule

bind sync_length_crc16_deframer_top sld_checker u_sld_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

### bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sld_pkg::*;

  // ---------------------------------------------------------------------------
  // dut signals, every input known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FIRST_SYNC;
  logic [7:0]            cfg_data  = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata  = '0;   // rx_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // body_byte, body_index, frame_length, frame_status, received_crc,
  // computed_crc, zero fill (lowest bit first)
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;        // result_kind
  logic                  out_tlast;        // last_of_frame

  sync_length_crc16_deframer_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // one expected result transaction, as the deframer should emit it
  typedef struct {
    bit            kind;        // 0 body byte, 1 verdict
    bit            last;
    bit [7:0]      body_byte;
    bit [7:0]      body_idx;
    bit [7:0]      frame_len;
    frame_status_t status;
    bit [15:0]     carried_crc;
    bit [15:0]     calc_crc;
  } deframe_result_t;

  deframe_result_t pending_results[$];

  // mirror of the deframer: sync values and receive state
  bit [7:0]    model_first_sync  = FIRST_SYNC_RST;
  bit [7:0]    model_second_sync = SECOND_SYNC_RST;
  hunt_state_t rx_phase = HUNT_FIRST;
  bit [7:0]    rx_len;
  bit [7:0]    rx_taken;        // packet bytes taken, length byte included
  bit [15:0]   rx_crc = CRC_INIT;
  bit [7:0]    rx_crc_lo;
  bit [7:0]    rx_crc_hi;

  // idle percentages for each side, changed per test phase
  int in_idle_pct  = 23;
  int out_idle_pct = 54;

  int n_errors;
  int n_checked;
  int n_body;
  int n_good;
  int n_crc_err;
  int n_bad_len;
  int n_rx_bytes;
  int n_noise_bytes;

  // ---------------------------------------------------------------------------
  // clock and timeout
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  // 2 ms is a generous bound on the slowest plausible run
  initial begin
    #2_000_000;
    $display("[sync_length_crc16_deframer_top] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // crc-16/modbus, bit-serial with the reflected polynomial
  function automatic bit [15:0] modbus_crc_step(input bit [15:0] acc, input bit [7:0] d);
    bit fb;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ d[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ CRC_POLY_REFL;
    end
    return acc;
  endfunction

  function automatic void expect_result(input bit kind, input bit [7:0] bb,
                                        input bit [7:0] idx, input bit [7:0] len,
                                        input frame_status_t st, input bit [15:0] rc,
                                        input bit [15:0] cc);
    deframe_result_t r;
    r.kind        = kind;
    r.last        = kind;
    r.body_byte   = bb;
    r.body_idx    = idx;
    r.frame_len   = len;
    r.status      = st;
    r.carried_crc = rc;
    r.calc_crc    = cc;
    pending_results = {pending_results, r};
  endfunction

  // packet byte at position pos: crc span, then the carried crc low and high
  function automatic void absorb_packet_byte(input int pos, input bit [7:0] b);
    if (pos + 2 < int'(rx_len)) rx_crc = modbus_crc_step(rx_crc, b);
    if (pos + 2 == int'(rx_len)) rx_crc_lo = b;
    if (pos + 1 == int'(rx_len)) rx_crc_hi = b;
  endfunction

  // advance the mirror by one accepted byte, queueing any result it causes
  function automatic void predict_rx(input bit [7:0] b);
    int        pos;
    bit [15:0] carried;
    if (rx_phase != COLLECT) begin
      if (rx_phase == HUNT_FIRST && b == model_first_sync) rx_phase = SEEN_FIRST;
      // equal sync values fall straight through to collecting here
      if (rx_phase == SEEN_FIRST && b == model_second_sync) begin
        rx_phase  = COLLECT;
        rx_taken  = '0;
        rx_len    = '0;
        rx_crc    = CRC_INIT;
        rx_crc_lo = '0;
        rx_crc_hi = '0;
      end
    end else if (rx_taken == 0) begin
      rx_len = b;
      if (b < MIN_LENGTH) begin
        rx_phase = HUNT_FIRST;
        expect_result(1'b1, 8'd0, 8'd0, b, ST_BAD_LEN, 16'd0, 16'd0);
      end else begin
        absorb_packet_byte(0, b);
        rx_taken = 8'd1;
      end
    end else if (rx_taken >= rx_len) begin
      // closing byte, value ignored
      carried = {rx_crc_hi, rx_crc_lo};
      expect_result(1'b1, 8'd0, 8'd0, rx_len,
                    (carried == rx_crc) ? ST_GOOD : ST_CRC_ERR, carried, rx_crc);
      rx_phase = HUNT_FIRST;
      rx_taken = '0;
    end else begin
      pos = rx_taken;
      absorb_packet_byte(pos, b);
      rx_taken = 8'(pos + 1);
      if (pos + 2 < int'(rx_len))
        expect_result(1'b0, b, 8'(pos - 1), rx_len, ST_GOOD, 16'd0, 16'd0);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one input transaction; valid is left high so back-to-back bytes need no gap
  task automatic send_byte(input bit [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_rx(b);
    n_rx_bytes++;
  endtask

  // sync(s), length, body, carried crc low/high, closing byte.
  // body holds len-3 bytes, or for length two the single byte after the length
  task automatic send_frame(input bit [7:0] len, input bit [7:0] body[$],
                            input bit crc_ok, input bit single_sync);
    bit [15:0] crc;
    send_byte(model_first_sync);
    if (!single_sync) send_byte(model_second_sync);
    send_byte(len);
    if (len >= 3) begin
      crc = modbus_crc_step(CRC_INIT, len);
      foreach (body[k]) begin
        send_byte(body[k]);
        crc = modbus_crc_step(crc, body[k]);
      end
      if (!crc_ok) crc = crc ^ (16'd1 << $urandom_range(15));
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
    end else if (len == 2) begin
      // carried crc is the length byte and this one, can never match 0xffff
      send_byte((body.size() != 0) ? body[0] : 8'($urandom_range(255)));
    end
    if (len >= 2) send_byte(8'($urandom_range(255)));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [7:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_FIRST_SYNC) model_first_sync = val;
    else model_second_sync = val;
  endtask

  // stop sending, wait for every expected result, then let the pipe settle
  task automatic drain_results;
    int waited;
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  // one random sequence: mostly well-formed frames, some noise and stray bytes
  task automatic send_random_sequence;
    int       pick;
    int       n;
    bit [7:0] len;
    bit [7:0] body[$];
    pick = $urandom_range(99);
    if (pick < 8) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        send_byte(8'($urandom_range(255)));
        n_noise_bytes++;
      end
    end else begin
      // broken start: first sync followed by stray bytes
      if (pick < 16) begin
        send_byte(model_first_sync);
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
      end
      pick = $urandom_range(99);
      if (pick < 6)       len = 8'($urandom_range(1));
      else if (pick < 11) len = 8'd2;
      else if (pick < 13) len = 8'($urandom_range(128, 255));
      else                len = 8'($urandom_range(3, 24));
      if (len == 2) body = {body, 8'($urandom_range(255))};
      if (len >= 3) repeat (len - 3) body = {body, 8'($urandom_range(255))};
      send_frame(len, body, $urandom_range(99) < 80, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset sync values: bad lengths, stray byte after first sync, shortest frames
  task automatic test_directed_frames;
    bit [7:0] none[$];
    send_frame(8'd0, none, 1'b1, 1'b0);
    send_frame(8'd1, none, 1'b1, 1'b0);
    // stray byte keeps it waiting, then a repeated first sync also just waits
    send_byte(model_first_sync);
    send_byte(8'h13);
    send_frame(8'd3, none, 1'b1, 1'b0);
    send_frame(8'd2, '{8'hFF}, 1'b1, 1'b0);
    send_frame(8'd5, '{8'h00, 8'hFF}, 1'b0, 1'b0);
  endtask

  // both sync values equal: one byte starts a frame, a second reads as length zero
  task automatic test_equal_syncs;
    bit [7:0] none[$];
    drain_results();
    write_reg(CFG_FIRST_SYNC, 8'h00);
    write_reg(CFG_SECOND_SYNC, 8'h00);
    send_frame(8'd4, '{8'h7E}, 1'b1, 1'b1);
    send_byte(8'h00);
    send_byte(8'h00);
    send_frame(8'd3, none, 1'b0, 1'b1);
  endtask

  // random traffic under one idling mix and one pair of sync values
  task automatic test_random_traffic(input int tx_idle, input int rx_idle,
                                     input bit [7:0] sync_a, input bit [7:0] sync_b,
                                     input int target, input bit with_longest);
    int       start;
    bit [7:0] body[$];
    drain_results();
    in_idle_pct  = tx_idle;
    out_idle_pct = rx_idle;
    write_reg(CFG_FIRST_SYNC, sync_a);
    write_reg(CFG_SECOND_SYNC, sync_b);
    start = n_rx_bytes - n_noise_bytes;
    // longest frame once: body index runs up to 251
    if (with_longest) begin
      repeat (252) body = {body, 8'($urandom_range(255))};
      send_frame(8'd255, body, 1'b1, 1'b0);
    end
    while (n_rx_bytes - n_noise_bytes - start < target) send_random_sequence();
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure and the checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin : check_results
    out_data_t       got;
    deframe_result_t want;
    bit              bad;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_data_t'(out_tdata);
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("%0t: unexpected result, kind %0d last %0d tdata %h",
                   $realtime, out_tuser, out_tlast, out_tdata);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        bad = (out_tuser !== want.kind) || (out_tlast !== want.last)
           || (got.body_byte !== want.body_byte) || (got.body_index !== want.body_idx)
           || (got.frame_length !== want.frame_len) || (got.frame_status !== want.status)
           || (got.received_crc !== want.carried_crc)
           || (got.computed_crc !== want.calc_crc) || (got.pad !== 6'd0);
        if (bad) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("%0t: mismatch, expected kind %0d last %0d byte %h idx %0d len %0d",
                     $realtime, want.kind, want.last, want.body_byte, want.body_idx,
                     want.frame_len);
            $display("    status %0d rx_crc %h calc_crc %h", want.status,
                     want.carried_crc, want.calc_crc);
            $display("  got kind %0d last %0d byte %h idx %0d len %0d status %0d",
                     out_tuser, out_tlast, got.body_byte, got.body_index,
                     got.frame_length, got.frame_status);
            $display("    rx_crc %h calc_crc %h fill %h", got.received_crc,
                     got.computed_crc, got.pad);
          end
        end
        if (!want.kind) n_body++;
        else begin
          case (want.status)
            ST_GOOD:    n_good++;
            ST_CRC_ERR: n_crc_err++;
            default:    n_bad_len++;
          endcase
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_equal_syncs();
    // sender idles lightly, receiver heavily; extreme sync values
    test_random_traffic(23, 54, 8'hFF, 8'h00, 230, 1'b0);
    // roles swapped, random sync values (may coincide)
    test_random_traffic(54, 23, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        230, 1'b0);
    // full rate both ways, back to the reset sync values
    test_random_traffic(0, 0, FIRST_SYNC_RST, SECOND_SYNC_RST, 230, 1'b1);

    drain_results();
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      n_errors += pending_results.size();
    end

    $display("sent %0d bytes (%0d noise) over four sync settings and three idling mixes",
             n_rx_bytes, n_noise_bytes);
    $display("checked %0d results: %0d body bytes, %0d good, %0d crc errors, %0d bad lengths",
             n_checked, n_body, n_good, n_crc_err, n_bad_len);
    if (n_errors == 0) begin
      $display("[sync_length_crc16_deframer_top] OK");
    end else begin
      $display("[sync_length_crc16_deframer_top] ERROR");
    end
    $finish;
  end

endmodule

### sync_length_crc16_deframer_top.f
src/sld_pkg.sv
src/sld_front.sv
src/sld_queue.sv
src/sld_back.sv
src/sync_length_crc16_deframer_top.sv
src/sld_checker.sv
bench/testbench.sv
